FILE: rtl/v4n_pkg.sv
// Package for the four-component vector normalizer.
// Holds shared widths, the outcome and register codes, and the beat structs.
// No dependencies.
package v4n_pkg;

  localparam int unsigned CompW       = 32;
  localparam int unsigned TolW        = 32;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned ShiftW      = 5;
  localparam int unsigned RootW       = 33;

  typedef enum logic [1:0] {
    OUT_SCALED = 2'd0,
    OUT_UNIT   = 2'd1,
    OUT_ZERO   = 2'd2
  } outcome_e;

  typedef enum logic {
    REG_UNIT_TOL = 1'b0,
    REG_ZERO_TOL = 1'b1
  } reg_idx_e;

  typedef logic signed [CompW-1:0] comp_t;
  typedef comp_t [3:0] vec_t;

  typedef struct packed {
    vec_t     comp;
    outcome_e outcome;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [63:0]       t;
    logic [ShiftW-1:0] s;
    logic              hi;
  } front_out_t;

  typedef struct packed {
    item_t             item;
    logic [ShiftW-1:0] s;
    logic [RootW-1:0]  root;
  } sqrt_out_t;

endpackage

FILE: rtl/vector4_normalize_core.sv
// Normalizes a signed Q16.16 four-component vector, passing near-unit vectors and zeroing tiny ones.
// Takes one vector per cycle while the output is not stalled. It uses the 32-stage square-root
// pipeline and the FracBits + 1 stage divider. Depends on v4n_pkg, v4n_front, v4n_sqrt and v4n_div.
module vector4_normalize_core #(
  parameter int unsigned FracBits = v4n_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [v4n_pkg::TolW-1:0]         cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [v4n_pkg::CompW-1:0] comp_x_i,
  input  logic signed [v4n_pkg::CompW-1:0] comp_y_i,
  input  logic signed [v4n_pkg::CompW-1:0] comp_z_i,
  input  logic signed [v4n_pkg::CompW-1:0] comp_w_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [v4n_pkg::CompW-1:0] unit_x_o,
  output logic signed [v4n_pkg::CompW-1:0] unit_y_o,
  output logic signed [v4n_pkg::CompW-1:0] unit_z_o,
  output logic signed [v4n_pkg::CompW-1:0] unit_w_o,
  output logic [1:0]                       outcome_o
);
  import v4n_pkg::*;

  localparam logic signed [31:0] QMax = 32'sd1 <<< FracBits;

  logic [TolW-1:0] unit_tol_q, zero_tol_q;
  logic            adv;
  vec_t            vec_in, vec_out;
  logic            fr_valid, sq_valid;
  front_out_t      fr_data;
  sqrt_out_t       sq_data;
  outcome_e        outcome;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_tol_q <= '0;
      zero_tol_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UNIT_TOL: unit_tol_q <= cfg_wdata_i;
        REG_ZERO_TOL: zero_tol_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  assign vec_in[0] = comp_x_i;
  assign vec_in[1] = comp_y_i;
  assign vec_in[2] = comp_z_i;
  assign vec_in[3] = comp_w_i;

  v4n_front #(.FracBits(FracBits)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (in_valid_i),
    .vec_i      (vec_in),
    .unit_tol_i (unit_tol_q),
    .zero_tol_i (zero_tol_q),
    .valid_o    (fr_valid),
    .data_o     (fr_data)
  );

  v4n_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (sq_valid),
    .data_o  (sq_data)
  );

  v4n_div #(.FracBits(FracBits)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (sq_valid),
    .data_i    (sq_data),
    .valid_o   (out_valid_o),
    .vec_o     (vec_out),
    .outcome_o (outcome)
  );

  assign unit_x_o  = vec_out[0];
  assign unit_y_o  = vec_out[1];
  assign unit_z_o  = vec_out[2];
  assign unit_w_o  = vec_out[3];
  assign outcome_o = outcome;

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUT_ZERO |->
      unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0 && unit_w_o == '0)
    else $error("zero outcome with nonzero components");

  a_scaled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUT_SCALED |->
      unit_x_o <= QMax && unit_x_o >= -QMax && unit_y_o <= QMax && unit_y_o >= -QMax &&
      unit_z_o <= QMax && unit_z_o >= -QMax && unit_w_o <= QMax && unit_w_o >= -QMax)
    else $error("scaled component beyond unit magnitude");

  a_root_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid && sq_data.item.outcome == OUT_SCALED |-> sq_data.root[32] || sq_data.root[31])
    else $error("root not normalized on scaling path");

endmodule

FILE: rtl/v4n_front.sv
// Front end: squares, squared-length sum, classification and even-shift normalization.
// Depends on v4n_pkg.
module v4n_front #(
  parameter int unsigned FracBits = v4n_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  v4n_pkg::vec_t             vec_i,
  input  logic [v4n_pkg::TolW-1:0]  unit_tol_i,
  input  logic [v4n_pkg::TolW-1:0]  zero_tol_i,
  output logic                      valid_o,
  output v4n_pkg::front_out_t       data_o
);
  import v4n_pkg::*;

  localparam int unsigned Depth = 11;
  localparam logic [64:0] One = 65'd1 << (2 * FracBits);

  logic [Depth-1:0] vld_q;

  vec_t              v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [3:0][31:0]  m1_q;
  logic [3:0][63:0]  sq2_q;
  logic [1:0][63:0]  p3_q;
  logic [64:0]       sum4_q, sum5_q, diff5_q;
  logic              zero5_q;
  item_t             item6_q;
  logic [63:0]       t6_q;
  logic              hi6_q;

  logic [63:0]       tn_q [5];
  logic [ShiftW-1:0] sn_q [5];
  item_t             in_q [5];
  logic              hn_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q <= vec_i;
      for (int i = 0; i < 4; i++) begin
        m1_q[i] <= vec_i[i][31] ? (~vec_i[i] + 32'd1) : vec_i[i];
      end
      v2_q <= v1_q;
      for (int i = 0; i < 4; i++) begin
        sq2_q[i] <= 64'(m1_q[i]) * 64'(m1_q[i]);
      end
      v3_q    <= v2_q;
      p3_q[0] <= sq2_q[0] + sq2_q[1];
      p3_q[1] <= sq2_q[2] + sq2_q[3];
      v4_q    <= v3_q;
      sum4_q  <= {1'b0, p3_q[0]} + {1'b0, p3_q[1]};
      v5_q    <= v4_q;
      sum5_q  <= sum4_q;
      diff5_q <= (sum4_q >= One) ? (sum4_q - One) : (One - sum4_q);
      zero5_q <= !sum4_q[64] && (sum4_q[63:32] == '0) && (sum4_q[31:0] <= zero_tol_i);
      item6_q.comp <= v5_q;
      if (!sum5_q[64] && (diff5_q[64:32] == '0) && (diff5_q[31:0] <= unit_tol_i)) begin
        item6_q.outcome <= OUT_UNIT;
      end else if (zero5_q) begin
        item6_q.outcome <= OUT_ZERO;
      end else begin
        item6_q.outcome <= OUT_SCALED;
      end
      t6_q  <= sum5_q[63:0];
      hi6_q <= sum5_q[64];
    end
  end

  for (genvar k = 0; k < 5; k++) begin : g_norm
    localparam int unsigned Sh = 32 >> k;
    logic [63:0]       t_in;
    logic [ShiftW-1:0] s_in;
    item_t             i_in;
    logic              h_in;

    if (k == 0) begin : g_first
      assign t_in = t6_q;
      assign s_in = '0;
      assign i_in = item6_q;
      assign h_in = hi6_q;
    end else begin : g_next
      assign t_in = tn_q[k-1];
      assign s_in = sn_q[k-1];
      assign i_in = in_q[k-1];
      assign h_in = hn_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t_in[63 -: Sh] == '0) begin
          tn_q[k] <= t_in << Sh;
          sn_q[k] <= s_in + ShiftW'(Sh / 2);
        end else begin
          tn_q[k] <= t_in;
          sn_q[k] <= s_in;
        end
        in_q[k] <= i_in;
        hn_q[k] <= h_in;
      end
    end
  end

  assign valid_o     = vld_q[Depth-1];
  assign data_o.item = in_q[4];
  assign data_o.t    = tn_q[4];
  assign data_o.s    = hn_q[4] ? '0 : sn_q[4];
  assign data_o.hi   = hn_q[4];

endmodule

FILE: rtl/v4n_sqrt.sv
// Pipelined integer square root of the normalized squared length, one root bit per stage.
// Depends on v4n_pkg.
module v4n_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  v4n_pkg::front_out_t data_i,
  output logic                valid_o,
  output v4n_pkg::sqrt_out_t  data_o
);
  import v4n_pkg::*;

  localparam int unsigned Steps = 32;

  logic [Steps-1:0]  vld_q;
  logic [33:0]       rem_q  [Steps];
  logic [31:0]       root_q [Steps];
  logic [63:0]       t_q    [Steps];
  item_t             item_q [Steps];
  logic [ShiftW-1:0] s_q    [Steps];
  logic              hi_q   [Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [33:0]       rem_in;
    logic [31:0]       root_in;
    logic [63:0]       t_in;
    item_t             i_in;
    logic [ShiftW-1:0] s_in;
    logic              h_in;
    logic [34:0]       rem_n;
    logic [34:0]       trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign t_in    = data_i.t;
      assign i_in    = data_i.item;
      assign s_in    = data_i.s;
      assign h_in    = data_i.hi;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign t_in    = t_q[j-1];
      assign i_in    = item_q[j-1];
      assign s_in    = s_q[j-1];
      assign h_in    = hi_q[j-1];
    end

    assign rem_n = {rem_in[32:0], t_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = rem_n >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? 34'(rem_n - trial) : 34'(rem_n);
        root_q[j] <= {root_in[30:0], ge};
        t_q[j]    <= t_in << 2;
        item_q[j] <= i_in;
        s_q[j]    <= s_in;
        hi_q[j]   <= h_in;
      end
    end
  end

  assign valid_o     = vld_q[Steps-1];
  assign data_o.item = item_q[Steps-1];
  assign data_o.s    = s_q[Steps-1];
  assign data_o.root = hi_q[Steps-1] ? (RootW'(1) << 32) : {1'b0, root_q[Steps-1]};

endmodule

FILE: rtl/v4n_div.sv
// Four-lane pipelined restoring divider by the root, with sign, saturation and result select.
// Depends on v4n_pkg.
module v4n_div #(
  parameter int unsigned FracBits = v4n_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  v4n_pkg::sqrt_out_t data_i,
  output logic               valid_o,
  output v4n_pkg::vec_t      vec_o,
  output v4n_pkg::outcome_e  outcome_o
);
  import v4n_pkg::*;

  localparam int unsigned Steps = FracBits + 1;
  localparam int unsigned Depth = FracBits + 3;

  typedef struct packed {
    item_t            item;
    logic [RootW-1:0] r;
  } side_t;

  logic [Depth-1:0] vld_q;
  side_t            side0_q;
  logic [3:0][32:0] a_q;
  side_t            side_q [Steps];
  logic [3:0][33:0] rem_q  [Steps];
  logic [3:0][31:0] quo_q  [Steps];
  vec_t             res_q;
  outcome_e         outcome_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side0_q.item <= data_i.item;
      side0_q.r    <= data_i.root;
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= 33'({32'd0, (data_i.item.comp[i][31] ? (~data_i.item.comp[i] + 32'd1)
                                                       : data_i.item.comp[i])} << data_i.s);
      end
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    side_t            s_in;
    logic [3:0][33:0] rem_in;
    logic [3:0][31:0] quo_in;
    logic [3:0]       ge;

    if (k == 0) begin : g_first
      assign s_in = side0_q;
      for (genvar i = 0; i < 4; i++) begin : g_lane
        assign rem_in[i] = {1'b0, a_q[i]};
        assign quo_in[i] = '0;
      end
    end else begin : g_next
      assign s_in = side_q[k-1];
      for (genvar i = 0; i < 4; i++) begin : g_lane
        assign rem_in[i] = {rem_q[k-1][i][32:0], 1'b0};
        assign quo_in[i] = quo_q[k-1][i];
      end
    end

    for (genvar i = 0; i < 4; i++) begin : g_cmp
      assign ge[i] = rem_in[i] >= {1'b0, s_in.r};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        for (int i = 0; i < 4; i++) begin
          rem_q[k][i] <= ge[i] ? (rem_in[i] - {1'b0, s_in.r}) : rem_in[i];
          quo_q[k][i] <= {quo_in[i][30:0], ge[i]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      outcome_q <= side_q[Steps-1].item.outcome;
      for (int i = 0; i < 4; i++) begin
        case (side_q[Steps-1].item.outcome)
          OUT_UNIT: begin
            res_q[i] <= side_q[Steps-1].item.comp[i];
          end
          OUT_ZERO: begin
            res_q[i] <= '0;
          end
          default: begin
            if (side_q[Steps-1].item.comp[i][31]) begin
              res_q[i] <= (quo_q[Steps-1][i] > 32'h8000_0000) ? 32'h8000_0000
                                                               : (~quo_q[Steps-1][i] + 32'd1);
            end else begin
              res_q[i] <= (quo_q[Steps-1][i] > 32'h7fff_ffff) ? 32'h7fff_ffff
                                                               : quo_q[Steps-1][i];
            end
          end
        endcase
      end
    end
  end

  assign valid_o   = vld_q[Depth-1];
  assign vec_o     = res_q;
  assign outcome_o = outcome_q;

endmodule
